>>> rtl/core/pms_pkg.sv
// shared types, constants and helpers of the particle motion step core
`timescale 1ns / 1ps
package pms_pkg;

  localparam int DATA_W        = 32;
  localparam int DRAG_W        = 16;
  localparam int AXES          = 3;
  localparam int MODE_W        = 2;
  localparam int AREA_W        = 13;
  localparam int PTR_W         = 14;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 14;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int SQ_W          = 64;
  localparam int SHIFT_W       = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_STILL   = 2'd0,
    MODE_DRAG    = 2'd1,
    MODE_SPEED   = 2'd2,
    MODE_POINTER = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_PTR_X  = 3'd3,
    REG_PTR_Y  = 3'd4,
    REG_HOLD   = 3'd5
  } cfg_reg_e;

  typedef logic [AXES-1:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    mode_e                    mode;
    logic [AREA_W-1:0]        width;
    logic [AREA_W-1:0]        height;
    logic signed [PTR_W-1:0]  ptr_x;
    logic signed [PTR_W-1:0]  ptr_y;
    logic                     hold;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] push_x;
    logic signed [DATA_W-1:0] push_y;
    logic signed [DATA_W-1:0] push_z;
    logic [DRAG_W-1:0]        damping;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_pos_z;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic signed [DATA_W-1:0] new_vel_z;
  } result_t;

  typedef struct packed {
    vec_t              pos;
    vec_t              vel;
    vec_t              push;
    logic [DRAG_W-1:0] damping;
  } side_t;

  typedef struct packed {
    vec_t            mag;
    logic [AXES-1:0] neg;
    logic            zero;
    side_t           side;
  } norm_t;

  typedef struct packed {
    logic [SQ_W-1:0] sum;
    norm_t           nrm;
  } sq_t;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    norm_t             nrm;
  } root_t;

  typedef struct packed {
    vec_t  unit;
    side_t side;
  } unit_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic [DATA_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] neg_sat32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    if (x == 32'h8000_0000) begin
      r = 32'h7fff_ffff;
    end else begin
      r = DATA_W'(-x);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/pms_stream_if.sv
// valid/ready stream channel carrying one word per handshake
`timescale 1ns / 1ps
interface pms_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/pms_front.sv
// vector select, magnitude scaling and sum of squares ahead of the root
`timescale 1ns / 1ps
module pms_front import pms_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output sq_t   out_data_o
);

  localparam int N = 6;

  logic [N-1:0] vld_q;
  logic [N:0]   go;

  side_t side0_d, side0_q;
  vec_t  c0_d, c0_q;
  norm_t nrm1_d, nrm1_q;
  norm_t nrm2_d, nrm2_q;
  logic [SHIFT_W-1:0] sh2_d, sh2_q;
  norm_t nrm3_d, nrm3_q;
  norm_t nrm4_q;
  logic [AXES-1:0][SQ_W-1:0] sq4_d, sq4_q;
  norm_t nrm5_q;
  logic [SQ_W-1:0] sum5_d, sum5_q;

  always_comb begin
    go[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = '{sum: sum5_q, nrm: nrm5_q};

  // stage 0: pick the vector to normalize
  always_comb begin
    logic signed [63:0] tx, ty, dx, dy;
    tx = 64'(cfg_i.ptr_x) <<< FRAC_BITS;
    ty = 64'(cfg_i.ptr_y) <<< FRAC_BITS;
    dx = tx - 64'(in_data_i.pos_x);
    dy = ty - 64'(in_data_i.pos_y);
    side0_d.pos     = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
    side0_d.vel     = {in_data_i.vel_z, in_data_i.vel_y, in_data_i.vel_x};
    side0_d.push    = {in_data_i.push_z, in_data_i.push_y, in_data_i.push_x};
    side0_d.damping = in_data_i.damping;
    if (cfg_i.mode == MODE_POINTER) begin
      c0_d = {in_data_i.push_z, sat32(dy), sat32(dx)};
    end else begin
      c0_d = side0_d.vel;
    end
  end

  // stage 1: magnitudes and signs
  always_comb begin
    nrm1_d.side = side0_q;
    nrm1_d.zero = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      nrm1_d.neg[i] = c0_q[i][DATA_W-1];
      nrm1_d.mag[i] = c0_q[i][DATA_W-1] ? DATA_W'(-c0_q[i]) : c0_q[i];
    end
  end

  // stage 2: shift count from the leading one of the largest magnitude
  always_comb begin
    logic [DATA_W-1:0] o;
    nrm2_d = nrm1_q;
    o = nrm1_q.mag[0] | nrm1_q.mag[1] | nrm1_q.mag[2];
    nrm2_d.zero = (o == '0);
    sh2_d = '0;
    for (int b = 0; b < DATA_W; b++) begin
      if (o[b]) begin
        sh2_d = (b >= DATA_W - 2) ? '0 : SHIFT_W'(DATA_W - 2 - b);
      end
    end
  end

  // stage 3: scale
  always_comb begin
    nrm3_d = nrm2_q;
    for (int i = 0; i < AXES; i++) begin
      nrm3_d.mag[i] = nrm2_q.mag[i] << sh2_q;
    end
  end

  // stage 4: squares
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sq4_d[i] = SQ_W'(nrm3_q.mag[i]) * SQ_W'(nrm3_q.mag[i]);
    end
  end

  // stage 5: sum
  assign sum5_d = sq4_q[0] + sq4_q[1] + sq4_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (go[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      side0_q <= side0_d;
      c0_q    <= c0_d;
    end
    if (go[1]) nrm1_q <= nrm1_d;
    if (go[2]) begin
      nrm2_q <= nrm2_d;
      sh2_q  <= sh2_d;
    end
    if (go[3]) nrm3_q <= nrm3_d;
    if (go[4]) begin
      nrm4_q <= nrm3_q;
      sq4_q  <= sq4_d;
    end
    if (go[5]) begin
      nrm5_q <= nrm4_q;
      sum5_q <= sum5_d;
    end
  end

endmodule

>>> rtl/core/pms_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module pms_isqrt import pms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  sq_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output root_t out_data_o
);

  localparam int N = SQRT_STEPS;

  logic [N-1:0] vld_q;
  logic [N:0]   go;

  logic [SQ_W-1:0] rem_d [N];
  logic [SQ_W-1:0] rem_q [N];
  logic [SQ_W-1:0] res_d [N];
  logic [SQ_W-1:0] res_q [N];
  norm_t           nrm_q [N];

  always_comb begin
    go[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = '{root: res_q[N-1][DATA_W-1:0], nrm: nrm_q[N-1]};

  always_comb begin
    logic [SQ_W-1:0] s_rem, s_res, bitv, trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        s_rem = in_data_i.sum;
        s_res = '0;
      end else begin
        s_rem = rem_q[k-1];
        s_res = res_q[k-1];
      end
      bitv  = SQ_W'(1) << (2 * (N - 1 - k));
      trial = s_res + bitv;
      if (s_rem >= trial) begin
        rem_d[k] = s_rem - trial;
        res_d[k] = (s_res >> 1) + bitv;
      end else begin
        rem_d[k] = s_rem;
        res_d[k] = s_res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (go[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (go[k]) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
      end
    end
    if (go[0]) nrm_q[0] <= in_data_i.nrm;
    for (int k = 1; k < N; k++) begin
      if (go[k]) nrm_q[k] <= nrm_q[k-1];
    end
  end

endmodule

>>> rtl/core/pms_div3.sv
// three pipelined restoring dividers forming the unit vector
`timescale 1ns / 1ps
module pms_div3 import pms_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  root_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output unit_t out_data_o
);

  localparam int Q  = FRAC_BITS + 1;
  localparam int NW = DATA_W + FRAC_BITS;
  localparam int N  = Q + 2;

  logic [N-1:0] vld_q;
  logic [N:0]   go;

  logic [AXES-1:0][DATA_W-1:0] rem_d [Q+1];
  logic [AXES-1:0][DATA_W-1:0] rem_q [Q+1];
  logic [AXES-1:0][Q-1:0]      low_d [Q+1];
  logic [AXES-1:0][Q-1:0]      low_q [Q+1];
  logic [AXES-1:0][Q-1:0]      quo_d [Q+1];
  logic [AXES-1:0][Q-1:0]      quo_q [Q+1];
  logic [DATA_W-1:0]           root_q [Q+1];
  norm_t                       nrm_q  [Q+1];
  unit_t                       fin_d, fin_q;

  always_comb begin
    go[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = fin_q;

  // rounded numerator, then one quotient bit per stage
  always_comb begin
    logic [NW-1:0]     num;
    logic [DATA_W:0]   t;
    for (int i = 0; i < AXES; i++) begin
      num = {in_data_i.nrm.mag[i], FRAC_BITS'(0)} + NW'(in_data_i.root[DATA_W-1:1]);
      rem_d[0][i] = DATA_W'(num[NW-1:Q]);
      low_d[0][i] = num[Q-1:0];
      quo_d[0][i] = '0;
    end
    for (int j = 1; j <= Q; j++) begin
      for (int i = 0; i < AXES; i++) begin
        t = {rem_q[j-1][i], low_q[j-1][i][Q-1]};
        low_d[j][i] = low_q[j-1][i] << 1;
        if (t >= {1'b0, root_q[j-1]}) begin
          rem_d[j][i] = DATA_W'(t - {1'b0, root_q[j-1]});
          quo_d[j][i] = {quo_q[j-1][i][Q-2:0], 1'b1};
        end else begin
          rem_d[j][i] = t[DATA_W-1:0];
          quo_d[j][i] = {quo_q[j-1][i][Q-2:0], 1'b0};
        end
      end
    end
  end

  // sign and zero vector
  always_comb begin
    logic [DATA_W-1:0] m;
    fin_d.side = nrm_q[Q].side;
    for (int i = 0; i < AXES; i++) begin
      m = DATA_W'(quo_q[Q][i]);
      if (nrm_q[Q].zero) begin
        fin_d.unit[i] = '0;
      end else if (nrm_q[Q].neg[i]) begin
        fin_d.unit[i] = DATA_W'(-m);
      end else begin
        fin_d.unit[i] = m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (go[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= Q; j++) begin
      if (go[j]) begin
        rem_q[j] <= rem_d[j];
        low_q[j] <= low_d[j];
        quo_q[j] <= quo_d[j];
      end
    end
    if (go[0]) begin
      root_q[0] <= in_data_i.root;
      nrm_q[0]  <= in_data_i.nrm;
    end
    for (int j = 1; j <= Q; j++) begin
      if (go[j]) begin
        root_q[j] <= root_q[j-1];
        nrm_q[j]  <= nrm_q[j-1];
      end
    end
    if (go[N-1]) fin_q <= fin_d;
  end

endmodule

>>> rtl/core/pms_integ.sv
// drag, force, euler step, wall bounce and hold
`timescale 1ns / 1ps
module pms_integ import pms_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  unit_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam int N      = 5;
  localparam int KW     = FRAC_BITS + 3;
  localparam int K_SLOW = (27 * (1 << FRAC_BITS) + 50) / 100;
  localparam int K_FAST = (24 * (1 << FRAC_BITS) + 5) / 10;
  localparam int K_PULL = (4 * (1 << FRAC_BITS) + 5) / 10;
  localparam int P1W    = DATA_W + DRAG_W + 1;
  localparam int P2W    = DATA_W + KW + 1;

  logic [N-1:0] vld_q;
  logic [N:0]   go;

  unit_t                         in0_q;
  logic signed [P1W-1:0]         prod0_d [AXES];
  logic signed [P1W-1:0]         prod0_q [AXES];
  vec_t                          pos1_q, vel1_d, vel1_q;
  vec_t                          pos2_q, vel2_q;
  logic signed [P2W-1:0]         prod2_d [AXES];
  logic signed [P2W-1:0]         prod2_q [AXES];
  vec_t                          pos3_d, pos3_q, vel3_q;
  result_t                       res4_d, res4_q;

  always_comb begin
    go[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = res4_q;

  // stage 0: drag product
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      prod0_d[i] = $signed(in_data_i.side.vel[i]) * $signed({1'b0, in_data_i.side.damping});
    end
  end

  // stage 1: new velocity
  always_comb begin
    logic signed [63:0] t;
    for (int i = 0; i < AXES; i++) begin
      t = ((64'(prod0_q[i]) + (64'sd1 <<< (DRAG_W - 1))) >>> DRAG_W);
      case (cfg_i.mode)
        MODE_DRAG:    vel1_d[i] = sat32(t + 64'($signed(in0_q.side.push[i])));
        MODE_POINTER: vel1_d[i] = sat32(t + 64'($signed(in0_q.unit[i])));
        MODE_SPEED:   vel1_d[i] = in0_q.unit[i];
        default:      vel1_d[i] = in0_q.side.vel[i];
      endcase
    end
  end

  // stage 2: step product
  always_comb begin
    logic [KW-1:0] k;
    case (cfg_i.mode)
      MODE_SPEED:   k = KW'(K_FAST);
      MODE_POINTER: k = KW'(K_PULL);
      default:      k = KW'(K_SLOW);
    endcase
    for (int i = 0; i < AXES; i++) begin
      prod2_d[i] = $signed(vel1_q[i]) * $signed({1'b0, k});
    end
  end

  // stage 3: new position
  always_comb begin
    logic signed [63:0] t;
    for (int i = 0; i < AXES; i++) begin
      t = ((64'(prod2_q[i]) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      if (cfg_i.mode == MODE_STILL) begin
        pos3_d[i] = pos2_q[i];
      end else begin
        pos3_d[i] = sat32(64'($signed(pos2_q[i])) + t);
      end
    end
  end

  // stage 4: walls and hold
  always_comb begin
    logic signed [63:0] px, py, wb, hb;
    vec_t p, v;
    p  = pos3_q;
    v  = vel3_q;
    px = 64'($signed(pos3_q[0]));
    py = 64'($signed(pos3_q[1]));
    wb = $signed(64'(cfg_i.width) << FRAC_BITS);
    hb = $signed(64'(cfg_i.height) << FRAC_BITS);
    if (cfg_i.mode == MODE_POINTER) begin
      if (px > wb) begin
        p[0] = wb[DATA_W-1:0];
        v[0] = neg_sat32(vel3_q[0]);
      end else if (px < 64'sd0) begin
        p[0] = '0;
        v[0] = neg_sat32(vel3_q[0]);
      end
      if (py > hb) begin
        p[1] = hb[DATA_W-1:0];
        v[1] = neg_sat32(vel3_q[1]);
      end else if (py < 64'sd0) begin
        p[1] = '0;
        v[1] = neg_sat32(vel3_q[1]);
      end
    end
    if (cfg_i.hold) v = '0;
    res4_d.new_pos_x = p[0];
    res4_d.new_pos_y = p[1];
    res4_d.new_pos_z = p[2];
    res4_d.new_vel_x = v[0];
    res4_d.new_vel_y = v[1];
    res4_d.new_vel_z = v[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (go[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      in0_q   <= in_data_i;
      prod0_q <= prod0_d;
    end
    if (go[1]) begin
      pos1_q <= in0_q.side.pos;
      vel1_q <= vel1_d;
    end
    if (go[2]) begin
      pos2_q  <= pos1_q;
      vel2_q  <= vel1_q;
      prod2_q <= prod2_d;
    end
    if (go[3]) begin
      pos3_q <= pos3_d;
      vel3_q <= vel2_q;
    end
    if (go[4]) res4_q <= res4_d;
  end

endmodule

>>> rtl/core/particle_motion_step_core.sv
// top level of the particle motion step core
//
// in_ch takes one particle word (position, velocity, force, drag) per
// valid/ready handshake; out_ch returns the updated position and velocity.
// the configuration port writes one register per cycle with cfg_we_i high;
// write it only while no word is in flight.
// every stage carries its own valid bit, so a new word can enter each cycle
// while out_ch takes words: throughput is one word per clock unless stalled.
// each word passes through vector select and sum of squares, the square root
// at one bit per stage, division at one quotient bit per stage, and then
// drag, euler step and wall clamp.
// when out_ch stalls, each stage holds its word and bubbles close up; the
// input stalls only once every stage is full.
// reset empties the pipeline and loads mode 1, a 1024 x 768 area, the
// pointer at the origin and hold cleared.
`timescale 1ns / 1ps
module particle_motion_step_core import pms_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pms_stream_if.sink            in_ch,
  pms_stream_if.source          out_ch
);

  cfg_t cfg_q;

  logic  f_valid, f_ready;
  sq_t   f_data;
  logic  s_valid, s_ready;
  root_t s_data;
  logic  d_valid, d_ready;
  unit_t d_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_DRAG;
      cfg_q.width  <= AREA_W'(1024);
      cfg_q.height <= AREA_W'(768);
      cfg_q.ptr_x  <= '0;
      cfg_q.ptr_y  <= '0;
      cfg_q.hold   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:   cfg_q.mode   <= mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_WIDTH:  cfg_q.width  <= cfg_data_i[AREA_W-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_data_i[AREA_W-1:0];
        REG_PTR_X:  cfg_q.ptr_x  <= $signed(cfg_data_i[PTR_W-1:0]);
        REG_PTR_Y:  cfg_q.ptr_y  <= $signed(cfg_data_i[PTR_W-1:0]);
        REG_HOLD:   cfg_q.hold   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pms_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  pms_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_data_o  (s_data)
  );

  pms_div3 #(.FRAC_BITS(FRAC_BITS)) u_div3 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .in_data_i   (s_data),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_data_o  (d_data)
  );

  pms_integ #(.FRAC_BITS(FRAC_BITS)) u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_data_i   (d_data),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_ch.data)
  );

endmodule
